### design/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared types, sizes and codes for the sorted priority queue.
// ============================================================================
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [15:0] prio;
    } entry_t;

endpackage

### design/spq_ram.sv
// ============================================================================
// spq_ram
// Job entry store: one write port, one read port, registered read data.
// ============================================================================
module spq_ram (
    input  logic                      clk,
    input  logic                      we,
    input  logic [spq_pkg::IDX_W-1:0] waddr,
    input  spq_pkg::entry_t           wdata,
    input  logic                      re,
    input  logic [spq_pkg::IDX_W-1:0] raddr,
    output spq_pkg::entry_t           rdata
);
    import spq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/sorted_priority_queue.sv
// ============================================================================
// sorted_priority_queue
// Job priority queue kept in descending priority order, ties in arrival order.
// ============================================================================
// Pulse start while busy is low to hand over one item: op selects add or pop,
// job_tag and job_priority carry the job for an add. Every item gives exactly
// one result, shown on status, out_tag, out_priority and occupancy for one
// cycle while done is high; the receiver must take it in that cycle, as the
// block cannot be stalled. Jobs live in a single-port-read, single-port-write
// RAM used as a ring: the ring head is the highest-priority job. A pop reads
// the head and advances it; S_POP_OUT registers the head job as its result.
// An add walks from the tail toward the head, moving each strictly lower job
// back one slot per cycle through the shared comparator and RAM port pair,
// then drops the new job into the gap; a walk that reaches the head ends in
// S_ADD_FIN, which writes the new job there. A full add, an empty pop and an
// add into an empty queue finish at once: done rises the next cycle and busy
// never rises. Busy is high for the rest of any longer operation.
// ============================================================================
module sorted_priority_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [15:0]        job_tag,
    input  logic signed [15:0] job_priority,
    output logic               done,
    output logic [1:0]         status,
    output logic [15:0]        out_tag,
    output logic signed [15:0] out_priority,
    output logic [4:0]         occupancy
);
    import spq_pkg::*;

    // Sequencer states
    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_ADD_CMP = 2'd1;
    localparam logic [1:0] S_ADD_FIN = 2'd2;
    localparam logic [1:0] S_POP_OUT = 2'd3;

    localparam int SUM_W = IDX_W + 2;

    // Map a queue position (0 = head) to a RAM address around the ring.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] k);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(k);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    entry_t           new_reg, new_next;

    logic               done_reg, done_next;
    logic [1:0]         status_reg, status_next;
    logic [15:0]        tag_out_reg, tag_out_next;
    logic signed [15:0] prio_out_reg, prio_out_next;
    logic [4:0]         occ_reg, occ_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_rdata;
    entry_t           in_entry;

    spq_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_entry.tag  = job_tag;
    assign in_entry.prio = job_priority;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        new_next      = new_reg;
        done_next     = 1'b0;
        status_next   = ST_OK;
        tag_out_next  = '0;
        prio_out_next = '0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = new_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    new_next = in_entry;
                    if (op == OP_ADD)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            // Full: drop the job, report at once
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            // Empty: the job becomes the head directly
                            ram_we     = 1'b1;
                            ram_waddr  = head_reg;
                            ram_wdata  = in_entry;
                            count_next = CNT_W'(1);
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            // Start the walk at the tail
                            ram_re     = 1'b1;
                            ram_raddr  = phys(head_reg, count_reg - CNT_W'(1));
                            pos_next   = count_reg;
                            state_next = S_ADD_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = head_reg;
                            state_next = S_POP_OUT;
                        end
                    end
                end
            end

            S_ADD_CMP:
            begin
                // rdata holds the job just ahead of the gap at pos_reg
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, pos_reg);
                if (ram_rdata.prio < new_reg.prio)
                begin
                    // Move the lower job back one slot, advance the gap
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - CNT_W'(1);
                    if (pos_reg == CNT_W'(1))
                    begin
                        state_next = S_ADD_FIN;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = phys(head_reg, pos_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    // Stored job is at least as high: settle behind it
                    ram_wdata  = new_reg;
                    count_next = count_reg + CNT_W'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_ADD_FIN:
            begin
                ram_we     = 1'b1;
                ram_waddr  = head_reg;
                ram_wdata  = new_reg;
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_POP_OUT:
            begin
                tag_out_next  = ram_rdata.tag;
                prio_out_next = ram_rdata.prio;
                head_next     = phys(head_reg, CNT_W'(1));
                count_next    = count_reg - CNT_W'(1);
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        occ_next = 5'(count_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload: hold the item under work and the result fields
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        new_reg      <= new_next;
        status_reg   <= status_next;
        tag_out_reg  <= tag_out_next;
        prio_out_reg <= prio_out_next;
        occ_reg      <= occ_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_tag      = tag_out_reg;
    assign out_priority = prio_out_reg;
    assign occupancy    = occ_reg;

endmodule
